// File: hdl/tpg_pkg.sv
// ----------------------------------------------------------------------------
// tpg_pkg: shared definitions for the test pattern pixel generator
// Pattern and register codes, widths, and the RGB565 packing helpers.
// ----------------------------------------------------------------------------
package tpg_pkg;

    localparam int MAX_RES     = 1024;
    localparam int COORD_W     = 10;
    localparam int RES_W       = 11;
    localparam int COLOR_W     = 16;
    localparam int ADDR_W      = 20;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int DIV_NUM_W   = 19;
    localparam int DIV_DEN_W   = 11;
    localparam int DIV_STAGES  = 10;
    localparam int BAR_IDX_W   = 3;

    typedef enum logic [2:0] {
        MODE_SOLID    = 3'd0,
        MODE_VBARS    = 3'd1,
        MODE_HBARS    = 3'd2,
        MODE_CHECKER  = 3'd3,
        MODE_GRADIENT = 3'd4
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE   = 3'd0,
        REG_WIDTH  = 3'd1,
        REG_HEIGHT = 3'd2,
        REG_COLOR1 = 3'd3,
        REG_COLOR2 = 3'd4,
        REG_CELL   = 3'd5,
        REG_ORDER  = 3'd6
    } t_reg_idx;

    // Side information that travels beside the dividers.
    typedef struct packed {
        logic                 visible;
        logic [ADDR_W-1:0]    addr;
        logic [BAR_IDX_W-1:0] bar_idx;
        logic                 zero0;
        logic                 zero1;
        logic                 zero2;
    } t_side;

    function automatic logic [COLOR_W-1:0] pack565(input logic [7:0] c0,
                                                   input logic [7:0] c1,
                                                   input logic [7:0] c2,
                                                   input logic       grb);
        logic [7:0] r;
        logic [7:0] g;
        r = grb ? c1 : c0;
        g = grb ? c0 : c1;
        return {r[7:3], g[7:2], c2[7:3]};
    endfunction

    function automatic logic [COLOR_W-1:0] bar_color(input logic [BAR_IDX_W-1:0] idx,
                                                     input logic grb);
        logic [COLOR_W-1:0] c;
        case (idx)
            3'd0: c = pack565(8'hFF, 8'h00, 8'h00, grb);
            3'd1: c = pack565(8'h00, 8'hFF, 8'h00, grb);
            3'd2: c = pack565(8'h00, 8'h00, 8'hFF, grb);
            3'd3: c = pack565(8'hFF, 8'hFF, 8'hFF, grb);
            3'd4: c = pack565(8'hFF, 8'hFF, 8'h00, grb);
            3'd5: c = pack565(8'hFF, 8'h00, 8'hFF, grb);
            3'd6: c = pack565(8'h00, 8'hFF, 8'hFF, grb);
            default: c = pack565(8'h00, 8'h00, 8'h00, grb);
        endcase
        return c;
    endfunction

endpackage

// File: hdl/tpg_div.sv
// ----------------------------------------------------------------------------
// tpg_div: pipelined restoring divider
// One quotient bit per register stage; the quotient must fit in ten bits.
// ----------------------------------------------------------------------------
module tpg_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [tpg_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [tpg_pkg::DIV_DEN_W-1:0] i_den,
    output logic [tpg_pkg::DIV_STAGES-1:0] o_quo
);
    import tpg_pkg::*;

    logic [DIV_NUM_W-1:0]  r_rem [0:DIV_STAGES-1];
    logic [DIV_DEN_W-1:0]  r_den [0:DIV_STAGES-1];
    logic [DIV_STAGES-1:0] r_quo [0:DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_quo[0] <= '0;
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
        localparam int B = DIV_STAGES - 1 - k;
        logic [DIV_NUM_W+1:0] sh;
        logic                 ge;
        assign sh = {{(DIV_NUM_W+2-DIV_DEN_W){1'b0}}, r_den[k]} << B;
        assign ge = {2'b00, r_rem[k]} >= sh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k+1] <= r_quo[k] | (DIV_STAGES'(ge) << B);
            end
        end
        // The last stage only needs its quotient bit.
        if (k < DIV_STAGES - 1) begin : g_pass
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= ge ? (r_rem[k] - sh[DIV_NUM_W-1:0]) : r_rem[k];
                    r_den[k+1] <= r_den[k];
                end
            end
        end
    end

    assign o_quo = r_quo[DIV_STAGES];

endmodule

// File: hdl/test_pattern_pixel_generator.sv
// ----------------------------------------------------------------------------
// test_pattern_pixel_generator: RGB565 test pattern per pixel coordinate
// Solid, vertical bars, horizontal bars, checkerboard and gradient patterns.
// ----------------------------------------------------------------------------
// The block takes one pixel coordinate per item and returns its RGB565
// pattern color, its framebuffer address y*width+x and an inside flag. It
// accepts one item every clock cycle while o_stall is low; each item passes
// twelve register stages. The depth is set by the ten-stage restoring
// dividers that produce the checkerboard cell numbers and the gradient
// channels. The whole pipeline advances together and freezes only when a
// finished result waits at the output under stall. The user must write the
// configuration registers through the plain write port only while no item
// is in flight; the block itself does not enforce this.
module test_pattern_pixel_generator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tpg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tpg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [tpg_pkg::COORD_W-1:0]    i_pixel_x,
    input  logic [tpg_pkg::COORD_W-1:0]    i_pixel_y,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [tpg_pkg::COLOR_W-1:0]    o_pixel_color,
    output logic [tpg_pkg::ADDR_W-1:0]     o_fb_address,
    output logic                           o_inside_res
);
    import tpg_pkg::*;

    // Configuration registers.
    t_mode              r_mode;
    logic [RES_W-1:0]   r_width;
    logic [RES_W-1:0]   r_height;
    logic [COLOR_W-1:0] r_color1;
    logic [COLOR_W-1:0] r_color2;
    logic [RES_W-1:0]   r_cell;
    logic               r_grb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_SOLID;
            r_width  <= RES_W'(480);
            r_height <= RES_W'(480);
            r_color1 <= '0;
            r_color2 <= '0;
            r_cell   <= RES_W'(32);
            r_grb    <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_MODE:   r_mode   <= t_mode'(i_cfg_data[2:0]);
                REG_WIDTH:  r_width  <= i_cfg_data[RES_W-1:0];
                REG_HEIGHT: r_height <= i_cfg_data[RES_W-1:0];
                REG_COLOR1: r_color1 <= i_cfg_data;
                REG_COLOR2: r_color2 <= i_cfg_data;
                REG_CELL:   r_cell   <= i_cfg_data[RES_W-1:0];
                REG_ORDER:  r_grb    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // The pipeline moves as one unit unless the output holds a result that
    // the receiver is stalling.
    logic adv;
    logic r_vout;
    assign adv     = !r_vout || !i_stall;
    assign o_stall = !adv;

    // Resolution saturates at the largest supported screen.
    logic [RES_W-1:0] w;
    logic [RES_W-1:0] h;
    assign w = (r_width  > RES_W'(MAX_RES)) ? RES_W'(MAX_RES) : r_width;
    assign h = (r_height > RES_W'(MAX_RES)) ? RES_W'(MAX_RES) : r_height;

    // Entry stage: address, inside test, bar index and divider operands.
    t_side                  n_side;
    logic [RES_W-1:0]       xe;
    logic [RES_W-1:0]       ye;
    logic [RES_W:0]         wh_sum;
    logic [RES_W-1:0]       pos;
    logic [RES_W-1:0]       bar_w;
    logic [BAR_IDX_W-1:0]   idx;
    logic [2*RES_W-1:0]     prod;
    logic [RES_W-1:0]       cs;
    logic [RES_W-1:0]       xy_sum;
    logic [DIV_NUM_W-1:0]   num0, num1, num2;
    logic [DIV_DEN_W-1:0]   den0, den1, den2;

    assign xe     = {1'b0, i_pixel_x};
    assign ye     = {1'b0, i_pixel_y};
    assign wh_sum = {1'b0, w} + {1'b0, h} - (RES_W+1)'(2);
    assign prod   = (2*RES_W)'(ye) * (2*RES_W)'(w) + (2*RES_W)'(xe);
    assign cs     = (r_cell == '0) ? RES_W'(1) : r_cell;
    assign xy_sum = xe + ye;

    // Bar index: number of bar boundaries k*(size/8) (k = 1..7, size the width or height)
    // at or before the coordinate; this also clamps to seven and covers zero bar width.
    always_comb begin
        pos   = (r_mode == MODE_HBARS) ? ye : xe;
        bar_w = ((r_mode == MODE_HBARS) ? h : w) >> 3;
        idx   = '0;
        for (int k = 1; k < 8; k++) begin
            if ({3'b000, pos} >= (RES_W+3)'(bar_w) * (RES_W+3)'(k)) begin
                idx = idx + BAR_IDX_W'(1);
            end
        end
    end

    always_comb begin
        if (r_mode == MODE_CHECKER) begin
            num0 = DIV_NUM_W'(xe);
            num1 = DIV_NUM_W'(ye);
            den0 = cs;
            den1 = cs;
        end else begin
            num0 = {DIV_NUM_W'(xe) << 8} - DIV_NUM_W'(xe);
            num1 = {DIV_NUM_W'(ye) << 8} - DIV_NUM_W'(ye);
            den0 = w - RES_W'(1);
            den1 = h - RES_W'(1);
        end
        num2 = (DIV_NUM_W'(xy_sum) << 8) - DIV_NUM_W'(xy_sum);
        den2 = wh_sum[RES_W-1:0];
    end

    always_comb begin
        n_side.visible = (xe < w) && (ye < h);
        n_side.addr    = prod[ADDR_W-1:0];
        n_side.bar_idx = idx;
        n_side.zero0   = (den0 == '0);
        n_side.zero1   = (den1 == '0);
        n_side.zero2   = (den2 == '0);
    end

    // Side data and valid bits follow the divider stages.
    t_side r_side [0:DIV_STAGES];
    logic  r_v    [0:DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[0] <= n_side;
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_side[k+1] <= r_side[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STAGES; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (adv) begin
            r_v[0] <= i_valid;
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_v[k+1] <= r_v[k];
            end
        end
    end

    logic [DIV_STAGES-1:0] q0, q1, q2;

    tpg_div u_div0 (.i_clk(i_clk), .i_en(adv), .i_num(num0), .i_den(den0), .o_quo(q0));
    tpg_div u_div1 (.i_clk(i_clk), .i_en(adv), .i_num(num1), .i_den(den1), .o_quo(q1));
    tpg_div u_div2 (.i_clk(i_clk), .i_en(adv), .i_num(num2), .i_den(den2), .o_quo(q2));

    // Final color selection, then the output register.
    t_side              s_last;
    logic [7:0]         g0, g1, g2;
    logic [COLOR_W-1:0] n_color;

    assign s_last = r_side[DIV_STAGES];
    assign g0     = s_last.zero0 ? 8'h00 : q0[7:0];
    assign g1     = s_last.zero1 ? 8'h00 : q1[7:0];
    assign g2     = s_last.zero2 ? 8'h00 : q2[7:0];

    always_comb begin
        case (r_mode)
            MODE_SOLID:    n_color = r_color1;
            MODE_VBARS:    n_color = bar_color(s_last.bar_idx, r_grb);
            MODE_HBARS:    n_color = bar_color(s_last.bar_idx, r_grb);
            MODE_CHECKER:  n_color = (q0[0] ^ q1[0]) ? r_color1 : r_color2;
            MODE_GRADIENT: n_color = pack565(g0, g1, g2, r_grb);
            default:       n_color = '0;
        endcase
        if (!s_last.visible) begin
            n_color = '0;
        end
    end

    logic [COLOR_W-1:0] r_color_out;
    logic [ADDR_W-1:0]  r_addr_out;
    logic               r_inside_out;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_color_out  <= n_color;
            r_addr_out   <= s_last.visible ? s_last.addr : '0;
            r_inside_out <= s_last.visible;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vout <= 1'b0;
        end else if (adv) begin
            r_vout <= r_v[DIV_STAGES];
        end
    end

    assign o_valid       = r_vout;
    assign o_pixel_color = r_color_out;
    assign o_fb_address  = r_addr_out;
    assign o_inside_res  = r_inside_out;

endmodule

// File: dv/test_pattern_pixel_generator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// test_pattern_pixel_generator_tb: self-checking bench for the pattern block
// Drives pixel coordinates under every pattern mode and many resolution,
// color, cell and channel-order settings. Each result is compared with a
// local model of the pattern math.
// ----------------------------------------------------------------------------
module test_pattern_pixel_generator_tb;
    import tpg_pkg::*;

    // Expected output of one accepted coordinate.
    typedef struct {
        logic [COLOR_W-1:0] color;
        logic [ADDR_W-1:0]  addr;
        logic               in_res;
    } t_pixel_exp;

    // The scoreboard keeps its own copy of the registers, computes the
    // pattern for every accepted coordinate and checks results in order.
    class pattern_scoreboard;
        int unsigned mode, width, height, color1, color2, cell_px, grb;
        t_pixel_exp  pending[$];
        int          errors;
        int          checked;

        function new();
            mode = 0; width = 480; height = 480; color1 = 0; color2 = 0;
            cell_px = 32; grb = 1; errors = 0; checked = 0;
        endfunction

        function void set_reg(int unsigned idx, int unsigned data);
            case (idx)
                REG_MODE:   mode    = data & 32'h7;
                REG_WIDTH:  width   = data & 32'h7FF;
                REG_HEIGHT: height  = data & 32'h7FF;
                REG_COLOR1: color1  = data & 32'hFFFF;
                REG_COLOR2: color2  = data & 32'hFFFF;
                REG_CELL:   cell_px = data & 32'h7FF;
                REG_ORDER:  grb     = data & 32'h1;
                default: ;
            endcase
        endfunction

        function int unsigned to565(int unsigned c0, int unsigned c1, int unsigned c2);
            int unsigned r, g;
            r = grb ? c1 : c0;
            g = grb ? c0 : c1;
            return ((r & 8'hF8) << 8) | ((g & 8'hFC) << 3) | ((c2 & 8'hF8) >> 3);
        endfunction

        function int unsigned bar_rgb(int unsigned pos, int unsigned res);
            int unsigned span, k;
            span = res / 8;
            k = (span == 0) ? 7 : pos / span;
            if (k > 7) k = 7;
            case (k)
                0: return to565(255, 0, 0);
                1: return to565(0, 255, 0);
                2: return to565(0, 0, 255);
                3: return to565(255, 255, 255);
                4: return to565(255, 255, 0);
                5: return to565(255, 0, 255);
                6: return to565(0, 255, 255);
                default: return to565(0, 0, 0);
            endcase
        endfunction

        function int unsigned ramp(int unsigned num, int unsigned den);
            if (den == 0) return 0;
            return ((num * 255) / den) & 32'hFF;
        endfunction

        // Work out the expected result of one accepted coordinate.
        function void note_pixel(int unsigned x, int unsigned y);
            t_pixel_exp  e;
            int unsigned w, h, cs, c;
            w = (width > MAX_RES) ? MAX_RES : width;
            h = (height > MAX_RES) ? MAX_RES : height;
            e.color = '0; e.addr = '0; e.in_res = 1'b0;
            if (x < w && y < h) begin
                case (mode)
                    MODE_SOLID:    c = color1;
                    MODE_VBARS:    c = bar_rgb(x, w);
                    MODE_HBARS:    c = bar_rgb(y, h);
                    MODE_CHECKER: begin
                        cs = (cell_px == 0) ? 1 : cell_px;
                        c = (((x / cs) + (y / cs)) & 1) ? color1 : color2;
                    end
                    MODE_GRADIENT: c = to565(ramp(x, w - 1), ramp(y, h - 1),
                                             ramp(x + y, w + h - 2));
                    default:       c = 0;
                endcase
                e.color  = c[COLOR_W-1:0];
                e.addr   = ADDR_W'(y * w + x);
                e.in_res = 1'b1;
            end
            pending.push_back(e);
        endfunction

        function void check_pixel(logic [COLOR_W-1:0] color, logic [ADDR_W-1:0] addr,
                                  logic in_res);
            t_pixel_exp e;
            checked++;
            if (pending.size() == 0) begin
                $display("%0t: result with nothing expected: color %h addr %h inside %b",
                         $time, color, addr, in_res);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (color !== e.color) begin
                $display("%0t: pixel_color expected %h actual %h", $time, e.color, color);
                errors++;
            end
            if (addr !== e.addr) begin
                $display("%0t: fb_address expected %h actual %h", $time, e.addr, addr);
                errors++;
            end
            if (in_res !== e.in_res) begin
                $display("%0t: inside_res expected %b actual %b", $time, e.in_res, in_res);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [COORD_W-1:0]    px = '0;
    logic [COORD_W-1:0]    py = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [COLOR_W-1:0]    out_color;
    logic [ADDR_W-1:0]     out_addr;
    logic                  out_inside;

    pattern_scoreboard sb = new();

    // Set near the end of the run so that the last items flow without gaps.
    bit quiet = 1'b0;
    bit held_long = 1'b0;
    int items_sent = 0;
    int idle_cycles = 0;

    test_pattern_pixel_generator i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_valid       (in_valid),
        .o_stall       (in_stall),
        .i_pixel_x     (px),
        .i_pixel_y     (py),
        .o_valid       (out_valid),
        .i_stall       (out_stall),
        .o_pixel_color (out_color),
        .o_fb_address  (out_addr),
        .o_inside_res  (out_inside)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Output side: random stall bursts, one long hold-off while the sender
    // keeps offering items so the pipeline fills and backs up its input.
    initial begin
        int n;
        forever begin
            @(negedge clk);
            if (!held_long && sb.checked >= 250) begin
                held_long = 1'b1;
                out_stall <= 1'b1;
                repeat (120) @(negedge clk);
                out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 16);
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Results are sampled at the rising edge; an item moves when valid is
    // high and stall is low.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            sb.check_pixel(out_color, out_addr, out_inside);
        end
    end

    // The watchdog ends a run that stops moving.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= 3000) begin
                $display("test_pattern_pixel_generator_tb: done, errors");
                $finish;
            end
        end
    end

    task automatic write_reg(input t_reg_idx idx, input int unsigned data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we   <= 1'b0;
        sb.set_reg(idx, data[CFG_DATA_W-1:0]);
    endtask

    // Offer one item, with an optional idle burst first, and hold it until
    // the block takes it. Valid stays high into the next item.
    task automatic send_pixel(input int unsigned x, input int unsigned y);
        int n;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        in_valid <= 1'b1;
        px <= x[COORD_W-1:0];
        py <= y[COORD_W-1:0];
        forever begin
            @(posedge clk);
            if (!in_stall) break;
        end
        sb.note_pixel(x, y);
        items_sent++;
    endtask

    // Let every outstanding item come out, then a margin for the pipeline.
    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    function automatic int unsigned pick_res(int p);
        case (p % 7)
            0: return 8;
            1: return 1024;
            2: return 2047;
            3: return $urandom_range(1, 7);
            4: return 0;
            default: return $urandom_range(8, 1024);
        endcase
    endfunction

    initial begin
        int unsigned w, h, x, y;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: every mode at the reset resolution, at the corner
        // pixels and just past the right edge.
        write_reg(REG_COLOR1, 16'hFFFF);
        write_reg(REG_COLOR2, 16'h0000);
        for (int m = 0; m < 8; m++) begin
            write_reg(REG_MODE, m);
            send_pixel(0, 0);
            send_pixel(479, 479);
            send_pixel(480, 0);
            drain();
        end
        send_pixel(1023, 1023);
        drain();

        // Random part: each phase a fresh setting, most coordinates on screen.
        for (int p = 0; p < 14; p++) begin
            w = pick_res(p);
            h = pick_res(p + 3);
            write_reg(REG_MODE, p % 8);
            write_reg(REG_WIDTH, w);
            write_reg(REG_HEIGHT, h);
            write_reg(REG_COLOR1, (p == 1) ? 16'h0000 : $urandom_range(0, 65535));
            write_reg(REG_COLOR2, (p == 2) ? 16'hFFFF : $urandom_range(0, 65535));
            case (p % 5)
                0: write_reg(REG_CELL, 0);
                1: write_reg(REG_CELL, 1);
                2: write_reg(REG_CELL, 2047);
                3: write_reg(REG_CELL, 1024);
                default: write_reg(REG_CELL, $urandom_range(2, 64));
            endcase
            write_reg(REG_ORDER, p % 2);
            if (w > MAX_RES) w = MAX_RES;
            if (h > MAX_RES) h = MAX_RES;
            if (p == 13) quiet = 1'b1;
            for (int k = 0; k < 50; k++) begin
                if (w == 0 || h == 0 || $urandom_range(0, 9) == 0) begin
                    x = $urandom_range(0, 1023);
                    y = $urandom_range(0, 1023);
                end else begin
                    x = $urandom_range(0, w - 1);
                    y = $urandom_range(0, h - 1);
                end
                send_pixel(x, y);
            end
            drain();
        end

        $display("Sent %0d pixels over all eight mode codes and %0d checked results,",
                 items_sent, sb.checked);
        $display("with edge resolutions, cell sizes, both channel orders and stalls.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("test_pattern_pixel_generator_tb: done, clean");
        end else begin
            $display("test_pattern_pixel_generator_tb: done, errors");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/tpg_pkg.sv
hdl/tpg_div.sv
hdl/test_pattern_pixel_generator.sv
dv/test_pattern_pixel_generator_tb.sv
